// File: hw/rtl/dmfp_pkg.sv
package dmfp_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int ANSWER_HEADER_BYTES = 12;

  localparam logic [7:0] DOT_CHAR = 8'd46;
  localparam logic [7:0] LABEL_LEN_MAX = 8'd63;
  localparam logic [7:0] NAME_LIMIT_RESET = 8'd255;

  localparam logic [2:0] KIND_NAME_CHAR = 3'd0;
  localparam logic [2:0] KIND_QUESTION_DONE = 3'd1;
  localparam logic [2:0] KIND_ANSWER_HEADER = 3'd2;
  localparam logic [2:0] KIND_ANSWER_DATA = 3'd3;
  localparam logic [2:0] KIND_MESSAGE_DONE = 3'd4;
  localparam logic [2:0] KIND_MALFORMED = 3'd5;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HEADER,
    PH_QLEN,
    PH_QLABEL,
    PH_QTAIL,
    PH_AHDR,
    PH_ADATA,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    phase_t       phase;
    logic [3:0]   field_byte_count;
    logic [5:0]   label_bytes_left;
    logic [7:0]   name_length_so_far;
    logic [15:0]  questions_left;
    logic [15:0]  answers_left;
    logic [15:0]  data_bytes_left;
    logic [15:0]  current_index;
    logic [79:0]  field_accumulator;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]   item_kind;
    logic [7:0]   byte_value;
    logic [15:0]  record_index;
    logic [15:0]  name_reference;
    logic [15:0]  record_type;
    logic [15:0]  record_class;
    logic [31:0]  time_to_live;
    logic [15:0]  data_length;
  } result_t;

endpackage

// File: hw/rtl/dmfp_step.sv
module dmfp_step
  import dmfp_pkg::*;
(
  input  parse_state_t state_cur,
  input  logic [7:0]   name_limit,
  input  logic [7:0]   message_byte,
  input  logic         message_start,
  input  logic         message_end,
  output parse_state_t state_nxt,
  output result_t      result,
  output logic         result_valid
);

  parse_state_t s;
  parse_state_t n;
  result_t      res;
  logic         have;
  logic [79:0]  acc_shift;
  logic [3:0]   fbc_inc;
  logic [15:0]  dlen_new;
  logic [15:0]  qleft_dec;

  function automatic parse_state_t begin_records(parse_state_t st);
    parse_state_t r;
    r = st;
    r.field_byte_count = '0;
    if (st.questions_left != '0) begin
      r.phase = PH_QLEN;
      r.name_length_so_far = '0;
    end else if (st.answers_left != '0) begin
      r.phase = PH_AHDR;
    end else begin
      r.phase = PH_DONE;
    end
    return r;
  endfunction

  always_comb begin
    s = state_cur;
    if (message_start) begin
      s = '0;
      s.phase = PH_HEADER;
    end
    n = s;
    res = '0;
    res.record_index = s.current_index;
    have = 1'b0;
    acc_shift = {s.field_accumulator[71:0], message_byte};
    fbc_inc = s.field_byte_count + 4'd1;
    dlen_new = '0;
    qleft_dec = s.questions_left - 16'd1;

    case (s.phase)
      PH_HEADER: begin
        n.field_accumulator = acc_shift;
        n.field_byte_count = fbc_inc;
        if (fbc_inc >= 4'(HEADER_BYTES)) begin
          n.questions_left = acc_shift[63:48];
          n.answers_left = acc_shift[47:32];
          n.current_index = '0;
          n = begin_records(n);
        end
      end
      PH_QLEN: begin
        if (message_byte == 8'd0) begin
          n.phase = PH_QTAIL;
          n.field_byte_count = '0;
        end else if (message_byte > LABEL_LEN_MAX) begin
          res.item_kind = KIND_MALFORMED;
          have = 1'b1;
          n.phase = PH_ERROR;
        end else begin
          n.label_bytes_left = message_byte[5:0];
          n.phase = PH_QLABEL;
          if (s.name_length_so_far != '0) begin
            have = 1'b1;
            if (s.name_length_so_far >= name_limit) begin
              res.item_kind = KIND_MALFORMED;
              n.phase = PH_ERROR;
            end else begin
              n.name_length_so_far = s.name_length_so_far + 8'd1;
              res.item_kind = KIND_NAME_CHAR;
              res.byte_value = DOT_CHAR;
            end
          end
        end
      end
      PH_QLABEL: begin
        have = 1'b1;
        if (s.name_length_so_far >= name_limit) begin
          res.item_kind = KIND_MALFORMED;
          n.phase = PH_ERROR;
        end else begin
          n.name_length_so_far = s.name_length_so_far + 8'd1;
          res.item_kind = KIND_NAME_CHAR;
          res.byte_value = message_byte;
          n.label_bytes_left = s.label_bytes_left - 6'd1;
          if (s.label_bytes_left == 6'd1) begin
            n.phase = PH_QLEN;
          end
        end
      end
      PH_QTAIL: begin
        n.field_accumulator = acc_shift;
        n.field_byte_count = fbc_inc;
        if (fbc_inc >= 4'd4) begin
          have = 1'b1;
          res.item_kind = KIND_QUESTION_DONE;
          res.record_type = acc_shift[31:16];
          res.record_class = acc_shift[15:0];
          n.questions_left = qleft_dec;
          n.current_index = (qleft_dec != '0) ? s.current_index + 16'd1 : '0;
          n = begin_records(n);
        end
      end
      PH_AHDR: begin
        if (s.field_byte_count < 4'(ANSWER_HEADER_BYTES - 2)) begin
          n.field_accumulator = acc_shift;
          dlen_new = s.data_bytes_left;
        end else if (s.field_byte_count == 4'(ANSWER_HEADER_BYTES - 2)) begin
          dlen_new = {message_byte, 8'd0};
        end else begin
          dlen_new = s.data_bytes_left | {8'd0, message_byte};
        end
        n.data_bytes_left = dlen_new;
        n.field_byte_count = fbc_inc;
        if (fbc_inc >= 4'(ANSWER_HEADER_BYTES)) begin
          have = 1'b1;
          res.item_kind = KIND_ANSWER_HEADER;
          res.name_reference = s.field_accumulator[79:64];
          res.record_type = s.field_accumulator[63:48];
          res.record_class = s.field_accumulator[47:32];
          res.time_to_live = s.field_accumulator[31:0];
          res.data_length = dlen_new;
          n.field_byte_count = '0;
          if (dlen_new != '0) begin
            n.phase = PH_ADATA;
          end else begin
            n.answers_left = s.answers_left - 16'd1;
            n.current_index = s.current_index + 16'd1;
            n = begin_records(n);
          end
        end
      end
      PH_ADATA: begin
        have = 1'b1;
        res.item_kind = KIND_ANSWER_DATA;
        res.byte_value = message_byte;
        n.data_bytes_left = s.data_bytes_left - 16'd1;
        if (s.data_bytes_left == 16'd1) begin
          n.answers_left = s.answers_left - 16'd1;
          n.current_index = s.current_index + 16'd1;
          n = begin_records(n);
        end
      end
      default: begin
      end
    endcase

    if (message_end) begin
      if (n.phase == PH_ERROR) begin
        n.phase = PH_IDLE;
      end else if (n.phase == PH_DONE) begin
        if (!have) begin
          res = '0;
          have = 1'b1;
        end
        res.item_kind = KIND_MESSAGE_DONE;
        n.phase = PH_IDLE;
      end else if (n.phase != PH_IDLE) begin
        res = '0;
        res.item_kind = KIND_MALFORMED;
        res.record_index = n.current_index;
        have = 1'b1;
        n.phase = PH_IDLE;
      end
    end

    state_nxt = n;
    result = res;
    result_valid = have;
  end

endmodule

// File: hw/rtl/dns_message_field_parser.sv
// DNS message field parser: takes one message byte per word, starting at the 12-byte header
// (message_start on its first byte), and emits question name characters with dots between
// labels, one word per question when its type and class are in, one word per answer header
// (name reference, type, class, TTL, data length), one word per answer data byte, a message
// done word on a clean message_end, and a malformed word for a label length of 64 or more, a
// name longer than the cfg name limit, or an early end. Authority and additional records are
// skipped. Each word is registered at the input, parsed combinationally by the state
// update, and the result is registered at the output, so a new byte is taken every
// cycle while the output side keeps up.
// Write cfg only while the parser is idle.
module dns_message_field_parser
  import dmfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_message_byte,
  input  logic        in_message_start,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_item_kind,
  output logic [7:0]  out_byte_value,
  output logic [15:0] out_record_index,
  output logic [15:0] out_name_reference,
  output logic [15:0] out_record_type,
  output logic [15:0] out_record_class,
  output logic [31:0] out_time_to_live,
  output logic [15:0] out_data_length
);

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_start_r;
  logic         in_end_r;
  logic [7:0]   name_limit_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  result_t      res_r;
  result_t      res_nxt;
  logic         res_have;
  logic         out_valid_r;
  logic         advance;
  logic         fire;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;
  assign fire     = in_valid_r && advance;

  dmfp_step u_step (
    .state_cur     (state_r),
    .name_limit    (name_limit_r),
    .message_byte  (in_byte_r),
    .message_start (in_start_r),
    .message_end   (in_end_r),
    .state_nxt     (state_nxt),
    .result        (res_nxt),
    .result_valid  (res_have)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_byte_r  <= in_message_byte;
      in_start_r <= in_message_start;
      in_end_r   <= in_message_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_limit_r <= NAME_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      name_limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_have;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_have) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_item_kind      = res_r.item_kind;
  assign out_byte_value     = res_r.byte_value;
  assign out_record_index   = res_r.record_index;
  assign out_name_reference = res_r.name_reference;
  assign out_record_type    = res_r.record_type;
  assign out_record_class   = res_r.record_class;
  assign out_time_to_live   = res_r.time_to_live;
  assign out_data_length    = res_r.data_length;

endmodule

// File: tb/sv/tb_dns_message_field_parser.sv
module tb_dns_message_field_parser;
  import dmfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_message_byte = 8'd0;
  logic        in_message_start = 1'b0;
  logic        in_message_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_item_kind;
  logic [7:0]  out_byte_value;
  logic [15:0] out_record_index;
  logic [15:0] out_name_reference;
  logic [15:0] out_record_type;
  logic [15:0] out_record_class;
  logic [31:0] out_time_to_live;
  logic [15:0] out_data_length;

  dns_message_field_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_message_byte    (in_message_byte),
    .in_message_start   (in_message_start),
    .in_message_end     (in_message_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_item_kind      (out_item_kind),
    .out_byte_value     (out_byte_value),
    .out_record_index   (out_record_index),
    .out_name_reference (out_name_reference),
    .out_record_type    (out_record_type),
    .out_record_class   (out_record_class),
    .out_time_to_live   (out_time_to_live),
    .out_data_length    (out_data_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser mirror
  phase_t      ph;
  logic [3:0]  fcnt;
  logic [5:0]  lbl_left;
  logic [7:0]  name_len;
  logic [15:0] q_left;
  logic [15:0] a_left;
  logic [15:0] d_left;
  logic [15:0] cur_idx;
  logic [79:0] acc;
  logic [7:0]  name_limit = NAME_LIMIT_RESET;

  result_t     pend;
  bit          pend_valid;
  result_t     parsed_q[$];

  logic [7:0]  msg[$];
  bit          calm = 1'b0;
  int          errors = 0;
  int          quiet = 0;
  int          stall = 0;

  task automatic clear_parse();
    ph = PH_IDLE;
    fcnt = '0;
    lbl_left = '0;
    name_len = '0;
    q_left = '0;
    a_left = '0;
    d_left = '0;
    cur_idx = '0;
    acc = '0;
  endtask

  task automatic put_kind(input logic [2:0] kind);
    pend = '0;
    pend.item_kind = kind;
    pend.record_index = cur_idx;
    pend_valid = 1'b1;
  endtask

  task automatic flag_malformed();
    put_kind(KIND_MALFORMED);
    ph = PH_ERROR;
  endtask

  task automatic next_record();
    fcnt = '0;
    if (q_left != 0) begin
      ph = PH_QLEN;
      name_len = '0;
    end else if (a_left != 0) begin
      ph = PH_AHDR;
    end else begin
      ph = PH_DONE;
    end
  endtask

  task automatic emit_name_char(input logic [7:0] c);
    if (name_len >= name_limit) begin
      flag_malformed();
    end else begin
      name_len++;
      put_kind(KIND_NAME_CHAR);
      pend.byte_value = c;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic st, input logic en);
    pend_valid = 1'b0;
    if (st) begin
      clear_parse();
      ph = PH_HEADER;
    end
    case (ph)
      PH_HEADER: begin
        acc = {acc[71:0], b};
        fcnt++;
        if (fcnt >= HEADER_BYTES) begin
          q_left = acc[63:48];
          a_left = acc[47:32];
          cur_idx = '0;
          next_record();
        end
      end
      PH_QLEN: begin
        if (b == 8'd0) begin
          ph = PH_QTAIL;
          fcnt = '0;
        end else if (b > LABEL_LEN_MAX) begin
          flag_malformed();
        end else begin
          lbl_left = b[5:0];
          ph = PH_QLABEL;
          if (name_len != 0) emit_name_char(DOT_CHAR);
        end
      end
      PH_QLABEL: begin
        emit_name_char(b);
        if (ph == PH_QLABEL) begin
          lbl_left = lbl_left - 6'd1;
          if (lbl_left == 0) ph = PH_QLEN;
        end
      end
      PH_QTAIL: begin
        acc = {acc[71:0], b};
        fcnt++;
        if (fcnt >= 4) begin
          put_kind(KIND_QUESTION_DONE);
          pend.record_type = acc[31:16];
          pend.record_class = acc[15:0];
          q_left = q_left - 16'd1;
          cur_idx = (q_left != 0) ? cur_idx + 16'd1 : 16'd0;
          next_record();
        end
      end
      PH_AHDR: begin
        if (fcnt < ANSWER_HEADER_BYTES - 2) acc = {acc[71:0], b};
        else if (fcnt == ANSWER_HEADER_BYTES - 2) d_left = {b, 8'h00};
        else d_left = d_left | {8'h00, b};
        fcnt++;
        if (fcnt >= ANSWER_HEADER_BYTES) begin
          put_kind(KIND_ANSWER_HEADER);
          pend.name_reference = acc[79:64];
          pend.record_type = acc[63:48];
          pend.record_class = acc[47:32];
          pend.time_to_live = acc[31:0];
          pend.data_length = d_left;
          fcnt = '0;
          if (d_left != 0) begin
            ph = PH_ADATA;
          end else begin
            a_left = a_left - 16'd1;
            cur_idx = cur_idx + 16'd1;
            next_record();
          end
        end
      end
      PH_ADATA: begin
        put_kind(KIND_ANSWER_DATA);
        pend.byte_value = b;
        d_left = d_left - 16'd1;
        if (d_left == 0) begin
          a_left = a_left - 16'd1;
          cur_idx = cur_idx + 16'd1;
          next_record();
        end
      end
      default: ;
    endcase
    if (en) begin
      if (ph == PH_ERROR) begin
        ph = PH_IDLE;
      end else if (ph == PH_DONE) begin
        if (!pend_valid) begin
          pend = '0;
          pend_valid = 1'b1;
        end
        pend.item_kind = KIND_MESSAGE_DONE;
        ph = PH_IDLE;
      end else if (ph != PH_IDLE) begin
        put_kind(KIND_MALFORMED);
        ph = PH_IDLE;
      end
    end
    if (pend_valid) parsed_q.push_back(pend);
  endtask

  // input side
  task automatic send_byte(input logic [7:0] b, input logic st, input logic en);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_message_byte <= b;
    in_message_start <= st;
    in_message_end <= en;
    do @(posedge clk); while (!in_ready);
    parse_byte(b, st, en);
  endtask

  task automatic send_message(input bit with_end);
    for (int i = 0; i < msg.size(); i++)
      send_byte(msg[i], i == 0, with_end && (i == msg.size() - 1));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_name_limit(input logic [7:0] v);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    name_limit = v;
  endtask

  // message builders
  task automatic add_header(input logic [15:0] nq, input logic [15:0] na);
    msg.delete();
    repeat (4) msg.push_back(8'($urandom));
    msg.push_back(nq[15:8]);
    msg.push_back(nq[7:0]);
    msg.push_back(na[15:8]);
    msg.push_back(na[7:0]);
    repeat (4) msg.push_back(8'($urandom));
  endtask

  task automatic add_label(input int len);
    msg.push_back(8'(len));
    repeat (len) msg.push_back(8'($urandom));
  endtask

  task automatic add_question(input int nlab);
    repeat (nlab)
      add_label(($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8));
    msg.push_back(8'd0);
    repeat (4) msg.push_back(8'($urandom));
  endtask

  task automatic add_answer(input int dlen);
    repeat (10) msg.push_back(8'($urandom));
    msg.push_back(8'(dlen >> 8));
    msg.push_back(8'(dlen));
    repeat (dlen) msg.push_back(8'($urandom));
  endtask

  task automatic build_random_message();
    int nq;
    int na;
    nq = $urandom_range(0, 3);
    na = $urandom_range(0, 3);
    add_header(16'(nq), 16'(na));
    repeat (nq) add_question($urandom_range(0, 3));
    repeat (na) add_answer($urandom_range(0, 6));
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) msg.push_back(8'($urandom));
  endtask

  // tests
  task automatic test_well_formed();
    add_header(16'd1, 16'd1);
    add_label(3);
    add_label(2);
    msg.push_back(8'd0);
    repeat (4) msg.push_back(8'($urandom));
    add_answer(2);
    msg.push_back(8'hff);
    msg.push_back(8'h00);
    send_message(1'b1);
  endtask

  task automatic test_empty_and_final_record();
    add_header(16'd1, 16'd1);
    add_question(0);
    add_answer(1);
    send_message(1'b1);
    add_header(16'd0, 16'd0);
    send_message(1'b1);
    add_header(16'd1, 16'd0);
    add_question(1);
    send_message(1'b1);
    add_header(16'd0, 16'd1);
    add_answer(0);
    send_message(1'b1);
  endtask

  task automatic test_bad_label();
    add_header(16'd2, 16'd0);
    add_question(0);
    msg.push_back(8'd64);
    repeat (3) msg.push_back(8'($urandom));
    send_message(1'b1);
    add_header(16'd1, 16'd0);
    msg.push_back(8'hc0);
    msg.push_back(8'h0c);
    send_message(1'b1);
    add_header(16'd1, 16'd0);
    add_label(63);
    msg.push_back(8'd0);
    repeat (4) msg.push_back(8'($urandom));
    send_message(1'b1);
  endtask

  task automatic test_name_limit();
    set_name_limit(8'd5);
    add_header(16'd2, 16'd0);
    add_label(3);
    add_label(1);
    msg.push_back(8'd0);
    repeat (4) msg.push_back(8'($urandom));
    add_label(3);
    add_label(2);
    msg.push_back(8'd0);
    repeat (4) msg.push_back(8'($urandom));
    send_message(1'b1);
    set_name_limit(8'd1);
    add_header(16'd2, 16'd0);
    add_label(1);
    msg.push_back(8'd0);
    repeat (4) msg.push_back(8'($urandom));
    add_label(2);
    msg.push_back(8'd0);
    repeat (4) msg.push_back(8'($urandom));
    send_message(1'b1);
    set_name_limit(NAME_LIMIT_RESET);
  endtask

  task automatic test_early_end();
    add_header(16'd1, 16'd1);
    while (msg.size() > 5) void'(msg.pop_back());
    send_message(1'b1);
    add_header(16'hffff, 16'hffff);
    msg.push_back(8'd3);
    send_message(1'b1);
    add_header(16'd0, 16'd1);
    add_answer(4);
    void'(msg.pop_back());
    send_message(1'b1);
  endtask

  task automatic test_framing();
    repeat (3) send_byte(8'($urandom), 1'b0, 1'($urandom));
    add_header(16'd1, 16'd0);
    add_label(4);
    send_message(1'b0);
    add_header(16'd1, 16'd0);
    msg.push_back(8'd200);
    repeat (2) msg.push_back(8'($urandom));
    send_message(1'b0);
    add_header(16'd0, 16'd0);
    send_message(1'b1);
  endtask

  // data length with a nonzero high byte, cut short by the end
  task automatic test_long_answer();
    add_header(16'd0, 16'd1);
    repeat (10) msg.push_back(8'($urandom));
    msg.push_back(8'h01);
    msg.push_back(8'h04);
    repeat (5) msg.push_back(8'($urandom));
    send_message(1'b1);
  endtask

  task automatic test_random(input int n_items);
    int sent;
    int pick;
    int keep;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        build_random_message();
        send_message(1'b1);
      end else if (pick == 7) begin
        build_random_message();
        keep = $urandom_range(1, msg.size());
        while (msg.size() > keep) void'(msg.pop_back());
        send_message(1'($urandom));
      end else if (pick == 8) begin
        add_header(16'($urandom) | 16'd1, 16'($urandom));
        if ($urandom_range(0, 1) == 1) add_label($urandom_range(1, 5));
        msg.push_back(8'($urandom_range(64, 255)));
        repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom));
        send_message(1'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
      end
      if (pick <= 8) sent += msg.size();
      if (!calm && $urandom_range(0, 14) == 0) wait_drained();
    end
  endtask

  // output side
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall > 0) begin
      stall <= stall - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic string show(input result_t r);
    return $sformatf("kind=%0d byte=%h idx=%h ref=%h type=%h class=%h ttl=%h len=%h",
                     r.item_kind, r.byte_value, r.record_index, r.name_reference,
                     r.record_type, r.record_class, r.time_to_live, r.data_length);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_item_kind, out_byte_value, out_record_index, out_name_reference,
             out_record_type, out_record_class, out_time_to_live, out_data_length};
      if (parsed_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %s", show(got));
      end else begin
        want = parsed_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %s, got %s", show(want), show(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_dns_message_field_parser NOT OK");
      $finish;
    end
  end

  initial begin
    clear_parse();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_name_limit(NAME_LIMIT_RESET);
    test_well_formed();
    test_empty_and_final_record();
    test_bad_label();
    test_name_limit();
    test_early_end();
    test_framing();
    test_long_answer();
    test_random(40);
    set_name_limit(8'($urandom_range(1, 12)));
    test_random(25);
    set_name_limit(8'd1);
    test_random(15);
    set_name_limit(NAME_LIMIT_RESET);
    calm = 1'b1;
    test_random(40);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && parsed_q.size() == 0) begin
      $display("tb_dns_message_field_parser OK");
    end else begin
      $display("tb_dns_message_field_parser NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/dmfp_pkg.sv
hw/rtl/dmfp_step.sv
hw/rtl/dns_message_field_parser.sv
tb/sv/tb_dns_message_field_parser.sv
